// ===== rtl/wrns_pkg.sv =====
// ----------------------------------------------------------------------------
// wrns_pkg
// Shared widths, command and status codes, and divider handshake types for
// the waypoint ring with nearest-point start.
// ----------------------------------------------------------------------------
package wrns_pkg;

  localparam int MAX_POINTS = 64;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int IDX_W      = 31;
  localparam int COORD_W    = 32;
  localparam int LAP_W      = 32;
  localparam int DIST_W     = 2 * COORD_W + 1;

  localparam logic [IDX_W-1:0] IDX_MAX   = {IDX_W{1'b1}};
  localparam logic [LAP_W-1:0] LAP_EMPTY = {LAP_W{1'b1}};

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_FETCH  = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quot;
    logic [CNT_W-1:0] rem;
  } div_res_t;

endpackage

// ===== rtl/wrns_div.sv =====
// ----------------------------------------------------------------------------
// wrns_div
// Restoring divider, one quotient bit per cycle: visit index by point count.
// ----------------------------------------------------------------------------
module wrns_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wrns_pkg::div_req_t req,
  output wrns_pkg::div_res_t res
);
  import wrns_pkg::*;

  localparam int STEP_W = $clog2(IDX_W);

  logic [IDX_W-1:0]  quot_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  divisor_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W-1:0]  rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quot_r[IDX_W-1]};
    ge      = rem_sh >= {1'b0, divisor_r};
    rem_nxt = ge ? CNT_W'(rem_sh - {1'b0, divisor_r}) : rem_sh[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quot_r    <= req.dividend;
        divisor_r <= req.divisor;
        rem_r     <= '0;
        step_r    <= STEP_W'(IDX_W - 1);
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        quot_r <= {quot_r[IDX_W-2:0], ge};
        rem_r  <= rem_nxt;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

endmodule

// ===== rtl/waypoint_ring_nearest_start_top.sv =====
// ----------------------------------------------------------------------------
// waypoint_ring_nearest_start_top
// Waypoint list with append, nearest-point start, round-robin fetch and clear.
// ----------------------------------------------------------------------------
// Clear goes straight to the output state; append and fetch wait on the
// bit-serial divider (31 steps); start reads, differences, squares and compares
// each stored point in turn, using the single shared 32x32 squaring multiplier.
// One item at a time: in_tready is high only while the sequencer is idle.
// A result waits in the output register, so the next item may enter meanwhile.
// Reset (rst_n low, synchronous) empties the list and zeroes the visit index.
module waypoint_ring_nearest_start_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // pos_x [31:0], pos_y [63:32]
  input  logic [1:0]   in_tuser,   // cmd [1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // out_x [31:0], out_y [63:32],
                                   // lap_count [95:64], point_count [102:96]
  output logic [1:0]   out_tuser   // status [1:0]
);
  import wrns_pkg::*;

  localparam int OUT_RAW_W  = 3 * COORD_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    S_IDLE, S_APP, S_SC_RD, S_SC_DIFF, S_SC_SQX, S_SC_SQY, S_SC_CMP,
    S_DIV_GO, S_DIV_WAIT, S_F_RD, S_F_DATA, S_OUT
  } state_t;

  state_t state_r;

  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   index_r;
  logic [1:0]         cmd_r;
  logic [COORD_W-1:0] qx_r, qy_r;

  logic [CNT_W-1:0]   scan_i_r;
  logic [ADDR_W-1:0]  best_r;
  logic [DIST_W-1:0]  best_d_r;
  logic [COORD_W-1:0] dx_r, dy_r;
  logic [2*COORD_W-1:0] sqx_r, sqy_r;

  logic [COORD_W-1:0] res_x_r, res_y_r;
  logic [LAP_W-1:0]   res_lap_r;
  logic [1:0]         res_status_r;

  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]         out_user_r;

  // point store
  logic [COORD_W-1:0] mem_x [MAX_POINTS];
  logic [COORD_W-1:0] mem_y [MAX_POINTS];
  logic [COORD_W-1:0] rd_x_r, rd_y_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;

  div_req_t div_req;
  div_res_t div_res;

  logic [COORD_W:0]     dxa, dxb, dya, dyb;
  logic [COORD_W-1:0]   dx_abs, dy_abs;
  logic [COORD_W-1:0]   mul_op;
  logic [2*COORD_W-1:0] prod;
  logic [DIST_W-1:0]    sum_sq;
  logic                 closer;
  logic [ADDR_W-1:0]    best_sel;
  logic [CNT_W-1:0]     scan_i_inc;
  logic [CNT_W-1:0]     rem_inc;
  logic                 lap_wrap;

  wrns_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .res  (div_res)
  );

  assign div_req.start    = (state_r == S_DIV_GO);
  assign div_req.dividend = index_r;
  assign div_req.divisor  = count_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    // abs difference picks whichever order is non-negative
    dxa    = {rd_x_r[COORD_W-1], rd_x_r} - {qx_r[COORD_W-1], qx_r};
    dxb    = {qx_r[COORD_W-1], qx_r} - {rd_x_r[COORD_W-1], rd_x_r};
    dya    = {rd_y_r[COORD_W-1], rd_y_r} - {qy_r[COORD_W-1], qy_r};
    dyb    = {qy_r[COORD_W-1], qy_r} - {rd_y_r[COORD_W-1], rd_y_r};
    dx_abs = dxa[COORD_W] ? dxb[COORD_W-1:0] : dxa[COORD_W-1:0];
    dy_abs = dya[COORD_W] ? dyb[COORD_W-1:0] : dya[COORD_W-1:0];

    mul_op = (state_r == S_SC_SQX) ? dx_r : dy_r;
    prod   = mul_op * mul_op;

    sum_sq   = {1'b0, sqx_r} + {1'b0, sqy_r};
    closer   = sum_sq < best_d_r;
    best_sel = closer ? scan_i_r[ADDR_W-1:0] : best_r;
    scan_i_inc = scan_i_r + CNT_W'(1);

    rem_inc  = div_res.rem + CNT_W'(1);
    lap_wrap = (rem_inc == count_r);

    rd_addr = (state_r == S_F_RD) ? div_res.rem[ADDR_W-1:0] : scan_i_r[ADDR_W-1:0];
    wr_en   = (state_r == S_APP) && (count_r < CNT_W'(MAX_POINTS));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[count_r[ADDR_W-1:0]] <= qx_r;
      mem_y[count_r[ADDR_W-1:0]] <= qy_r;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      index_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT either reloads or holds the output register itself
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r        <= in_tuser;
            qx_r         <= in_tdata[COORD_W-1:0];
            qy_r         <= in_tdata[2*COORD_W-1:COORD_W];
            res_x_r      <= '0;
            res_y_r      <= '0;
            res_status_r <= ST_OK;
            res_lap_r    <= LAP_EMPTY;
            case (in_tuser)
              CMD_APPEND: state_r <= S_APP;
              CMD_START, CMD_FETCH: begin
                if (count_r == '0) begin
                  res_status_r <= ST_EMPTY;
                  state_r      <= S_OUT;
                end else if (in_tuser == CMD_START) begin
                  scan_i_r <= '0;
                  best_r   <= '0;
                  best_d_r <= '1;
                  state_r  <= S_SC_RD;
                end else begin
                  state_r <= S_DIV_GO;
                end
              end
              default: begin
                count_r <= '0;
                index_r <= '0;
                state_r <= S_OUT;
              end
            endcase
          end
        end

        S_APP: begin
          if (wr_en) begin
            count_r <= count_r + CNT_W'(1);
          end else begin
            res_status_r <= ST_FULL;
          end
          state_r <= S_DIV_GO;
        end

        S_SC_RD:   state_r <= S_SC_DIFF;

        S_SC_DIFF: begin
          dx_r    <= dx_abs;
          dy_r    <= dy_abs;
          state_r <= S_SC_SQX;
        end

        S_SC_SQX: begin
          sqx_r   <= prod;
          state_r <= S_SC_SQY;
        end

        S_SC_SQY: begin
          sqy_r   <= prod;
          state_r <= S_SC_CMP;
        end

        S_SC_CMP: begin
          // strict compare keeps the first of equal distances
          if (closer) begin
            best_d_r <= sum_sq;
          end
          best_r <= best_sel;
          if (scan_i_inc == count_r) begin
            index_r   <= IDX_W'(best_sel);
            res_lap_r <= '0;
            state_r   <= S_OUT;
          end else begin
            scan_i_r <= scan_i_inc;
            state_r  <= S_SC_RD;
          end
        end

        S_DIV_GO:  state_r <= S_DIV_WAIT;

        S_DIV_WAIT: begin
          if (div_res.done) begin
            if (cmd_r == CMD_FETCH) begin
              state_r <= S_F_RD;
            end else begin
              res_lap_r <= {1'b0, div_res.quot};
              state_r   <= S_OUT;
            end
          end
        end

        S_F_RD:    state_r <= S_F_DATA;

        S_F_DATA: begin
          res_x_r <= rd_x_r;
          res_y_r <= rd_y_r;
          // advance and bump the lap when the index crosses a multiple of count
          if (index_r != IDX_MAX) begin
            index_r   <= index_r + IDX_W'(1);
            res_lap_r <= {1'b0, div_res.quot + IDX_W'(lap_wrap)};
          end else begin
            res_lap_r <= {1'b0, div_res.quot};
          end
          state_r <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= OUT_DATA_W'({count_r, res_lap_r, res_y_r, res_x_r});
            out_user_r  <= res_status_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of waypoint_ring_nearest_start_top. Commands go in on the
// input channel and each result is compared against an in-bench model of the
// point list, the visit index and the squared-distance search. Directed cases
// cover the empty list, coordinate extremes, distance overflow into bit 64 and
// ties. Random segments then rebuild the list at random sizes and mix starts,
// fetches, appends and clears. Both channels idle in random bursts, except in
// the final segment.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wrns_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] lap;
    logic [6:0]  cnt;
    logic [1:0]  status;
  } waypoint_result_t;

  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] ONE       = 32'h0001_0000;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata   = '0;   // pos_x [31:0], pos_y [63:32]
  logic [1:0]   in_tuser   = '0;   // cmd [1:0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;         // out_x [31:0], out_y [63:32],
                                   // lap_count [95:64], point_count [102:96]
  logic [1:0]   out_tuser;         // status [1:0]

  // model state of the point list
  logic [31:0]       list_x [MAX_POINTS];
  logic [31:0]       list_y [MAX_POINTS];
  int unsigned       list_len;
  logic [IDX_W-1:0]  visit_idx;

  waypoint_result_t  pending_results [$];
  waypoint_result_t  got_result;
  waypoint_result_t  want_result;
  int                mismatches   = 0;
  int                items_sent   = 0;
  int                results_seen = 0;
  int                stall_left   = 0;
  bit                idle_en      = 1'b1;

  waypoint_ring_nearest_start_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // exact squared distance, wide enough to keep the carry out of bit 63
  function automatic logic [65:0] squared_distance(int unsigned idx,
                                                   logic [31:0] qx, logic [31:0] qy);
    logic signed [32:0] px, py, sx, sy;
    logic [32:0]        dx, dy;
    px = $signed({list_x[idx][31], list_x[idx]});
    py = $signed({list_y[idx][31], list_y[idx]});
    sx = $signed({qx[31], qx});
    sy = $signed({qy[31], qy});
    dx = (px >= sx) ? px - sx : sx - px;
    dy = (py >= sy) ? py - sy : sy - py;
    return {33'b0, dx} * {33'b0, dx} + {33'b0, dy} * {33'b0, dy};
  endfunction

  function automatic waypoint_result_t predict_waypoint(logic [1:0] cmd,
                                                        logic [31:0] x, logic [31:0] y);
    waypoint_result_t r;
    logic [65:0]      best_d, d;
    int unsigned      best, k;
    r = '0;
    case (cmd)
      CMD_APPEND: begin
        if (list_len >= MAX_POINTS) begin
          r.status = ST_FULL;
        end else begin
          list_x[list_len] = x;
          list_y[list_len] = y;
          list_len++;
        end
      end
      CMD_START: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best   = 0;
          best_d = squared_distance(0, x, y);
          for (int unsigned i = 1; i < list_len; i++) begin
            d = squared_distance(i, x, y);
            // strict compare: the earlier point keeps a tie
            if (d < best_d) begin
              best   = i;
              best_d = d;
            end
          end
          visit_idx = IDX_W'(best);
        end
      end
      CMD_FETCH: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          k   = visit_idx % list_len;
          r.x = list_x[k];
          r.y = list_y[k];
          if (visit_idx != IDX_MAX) visit_idx++;
        end
      end
      default: begin
        list_len  = 0;
        visit_idx = '0;
      end
    endcase
    r.lap = (list_len == 0) ? LAP_EMPTY : 32'(visit_idx / list_len);
    r.cnt = 7'(list_len);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s got %h expected %h", results_seen, what, got, want);
    mismatches++;
  endtask

  // result channel: check each item and drive stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
                    out_tdata[102:96], out_tuser};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", got_result.lap, '0);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.x != want_result.x)
          report_mismatch("out_x", got_result.x, want_result.x);
        if (got_result.y != want_result.y)
          report_mismatch("out_y", got_result.y, want_result.y);
        if (got_result.lap != want_result.lap)
          report_mismatch("lap_count", got_result.lap, want_result.lap);
        if (got_result.cnt != want_result.cnt)
          report_mismatch("point_count", 32'(got_result.cnt), 32'(want_result.cnt));
        if (got_result.status != want_result.status)
          report_mismatch("status", 32'(got_result.status), 32'(want_result.status));
      end
      results_seen++;
    end
    if (!idle_en) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [31:0] x, logic [31:0] y);
    int gap;
    waypoint_result_t predicted;
    gap = 0;
    if (idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_waypoint(cmd, x, y);
    pending_results = {pending_results, predicted};
    items_sent++;
  endtask

  // mostly random bits, some grid points to force ties, some extremes
  function automatic logic [31:0] pick_coord();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) return $urandom;
    if (mode < 8) return 32'((int'($urandom_range(0, 8)) - 4) * 65536);
    case ($urandom_range(0, 4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 32'hffff_ffff;
      3: return 32'd1;
      default: return '0;
    endcase
  endfunction

  task automatic test_empty_list();
    send_item(CMD_FETCH, '0, '0);
    send_item(CMD_START, ONE, ONE);
    send_item(CMD_CLEAR, '0, '0);
  endtask

  task automatic test_extremes();
    send_item(CMD_APPEND, COORD_MIN, COORD_MIN);
    send_item(CMD_APPEND, COORD_MIN, COORD_MAX);
    // first point's distance carries past bit 63, second one wins
    send_item(CMD_START, COORD_MAX, COORD_MAX);
    send_item(CMD_FETCH, '0, '0);
    send_item(CMD_FETCH, '0, '0);
    send_item(CMD_FETCH, '0, '0);
    send_item(CMD_APPEND, COORD_MAX, COORD_MAX);
    send_item(CMD_APPEND, '0, '0);
    send_item(CMD_START, COORD_MAX, COORD_MAX);
    send_item(CMD_FETCH, '0, '0);
    send_item(CMD_START, 32'hffff_ffff, 32'd1);
    send_item(CMD_FETCH, '0, '0);
  endtask

  task automatic test_nearest_ties();
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_APPEND, ONE, '0);
    send_item(CMD_APPEND, -ONE, '0);
    send_item(CMD_APPEND, '0, ONE);
    send_item(CMD_START, '0, '0);
    send_item(CMD_FETCH, '0, '0);
    send_item(CMD_START, '0, ONE << 1);
    send_item(CMD_FETCH, '0, '0);
    send_item(CMD_APPEND, ONE, '0);
    send_item(CMD_START, ONE, '0);
    send_item(CMD_FETCH, '0, '0);
  endtask

  task automatic test_full_list();
    send_item(CMD_CLEAR, '0, '0);
    repeat (MAX_POINTS) send_item(CMD_APPEND, pick_coord(), pick_coord());
    send_item(CMD_APPEND, pick_coord(), pick_coord());
    send_item(CMD_START, pick_coord(), pick_coord());
    repeat (70) send_item(CMD_FETCH, '0, '0);
    send_item(CMD_START, list_x[MAX_POINTS-1], list_y[MAX_POINTS-1]);
    repeat (3) send_item(CMD_FETCH, '0, '0);
  endtask

  // rebuild the list at a random size, then mix commands on it
  task automatic test_random_mix(int stop_at);
    int size, ops, pick;
    while (items_sent < stop_at) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      send_item(CMD_CLEAR, $urandom, $urandom);
      repeat (size) send_item(CMD_APPEND, pick_coord(), pick_coord());
      ops = $urandom_range(5, 30);
      repeat (ops) begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      send_item(CMD_START, pick_coord(), pick_coord());
        else if (pick < 85) send_item(CMD_FETCH, $urandom, $urandom);
        else if (pick < 96) send_item(CMD_APPEND, pick_coord(), pick_coord());
        else                send_item(CMD_CLEAR, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    list_len  = 0;
    visit_idx = '0;
    test_empty_list();
    test_extremes();
    test_nearest_ties();
    test_full_list();
    test_random_mix(1500);
    idle_en = 1'b0;
    test_random_mix(1700);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("waypoint_ring_nearest_start_top: match");
    else
      $display("waypoint_ring_nearest_start_top: mismatch");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("waypoint_ring_nearest_start_top: mismatch");
    $finish;
  end

endmodule
